// ===== rtl/tre_pkg.sv =====
// shared types and constants for the tga run-length pixel encoder
`default_nettype none
package tre_pkg;

  // packet constants
  localparam logic [7:0] HdrFlag   = 8'h80;
  localparam logic [7:0] MaxRun    = 8'd128;
  localparam logic [7:0] Opaque    = 8'd255;
  localparam logic [2:0] BytesRgb  = 3'd4;
  localparam logic [2:0] BytesRgba = 3'd5;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgSourceFormat = 2'd0,
    CfgWriteAlpha   = 2'd1,
    CfgImageWidth   = 2'd2
  } cfg_idx_e;

  // source layouts
  typedef enum logic [1:0] {
    FmtRgb  = 2'd0,
    FmtBgr  = 2'd1,
    FmtRgba = 2'd2,
    FmtBgra = 2'd3
  } src_fmt_e;

  // one run-length packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [2:0] bytes;
    logic       last;
  } pkt_t;

  // packets produced by one pixel, first in order in pkt_a
  typedef struct packed {
    logic [1:0] count;
    pkt_t       pkt_a;
    pkt_t       pkt_b;
  } push_t;

  // build the header byte from a run length
  function automatic logic [7:0] run_header(input logic [7:0] len);
    logic [7:0] lm1;
    lm1 = len - 8'd1;
    return HdrFlag | {1'b0, lm1[6:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tre_run_core.sv =====
// run tracking, line counting and packet forming for one pixel per cycle while take_i is high
`default_nettype none
module tre_run_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_addr_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            take_i,
  input  wire logic [7:0]      comp0_i,
  input  wire logic [7:0]      comp1_i,
  input  wire logic [7:0]      comp2_i,
  input  wire logic [7:0]      comp3_i,
  output tre_pkg::push_t       push_o
);

  logic [1:0]  src_fmt_q;
  logic        wr_alpha_q;
  logic [15:0] width_q;
  logic [31:0] run_pix_q, run_pix_d;
  logic [7:0]  run_len_q, run_len_d;
  logic [15:0] col_q, col_d;

  logic        has_alpha, diff, is_open, close_run, line_end;
  logic [31:0] pix, new_pix;
  logic [7:0]  new_len;
  logic [15:0] col_inc;
  tre_pkg::pkt_t pkt0, pkt1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q  <= tre_pkg::FmtRgb;
      wr_alpha_q <= 1'b0;
      width_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tre_pkg::CfgSourceFormat: src_fmt_q  <= cfg_wdata_i[1:0];
        tre_pkg::CfgWriteAlpha:   wr_alpha_q <= cfg_wdata_i[0];
        tre_pkg::CfgImageWidth:   width_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // reorder source bytes to b,g,r,a
  always_comb begin
    has_alpha = src_fmt_q[1];
    if (src_fmt_q[0]) begin
      pix[23:0] = {comp2_i, comp1_i, comp0_i};
    end else begin
      pix[23:0] = {comp0_i, comp1_i, comp2_i};
    end
    pix[31:24] = has_alpha ? comp3_i : tre_pkg::Opaque;
  end

  // run decision and line end
  always_comb begin
    diff = (run_pix_q[23:0] != pix[23:0]) ||
           (has_alpha && wr_alpha_q && (run_pix_q[31:24] != pix[31:24]));
    is_open   = run_len_q != 8'd0;
    close_run = is_open && (diff || (run_len_q >= tre_pkg::MaxRun));
    if (!is_open || close_run) begin
      new_pix = pix;
      new_len = 8'd1;
    end else begin
      new_pix = run_pix_q;
      new_len = run_len_q + 8'd1;
    end
    col_inc  = col_q + 16'd1;
    line_end = col_inc == width_q;
  end

  // packet for the closed run and for the run closed by the line end
  always_comb begin
    pkt0.header = tre_pkg::run_header(run_len_q);
    pkt0.blue   = run_pix_q[7:0];
    pkt0.green  = run_pix_q[15:8];
    pkt0.red    = run_pix_q[23:16];
    pkt0.alpha  = wr_alpha_q ? run_pix_q[31:24] : 8'd0;
    pkt0.bytes  = wr_alpha_q ? tre_pkg::BytesRgba : tre_pkg::BytesRgb;
    pkt0.last   = !line_end;

    pkt1.header = tre_pkg::run_header(new_len);
    pkt1.blue   = new_pix[7:0];
    pkt1.green  = new_pix[15:8];
    pkt1.red    = new_pix[23:16];
    pkt1.alpha  = wr_alpha_q ? new_pix[31:24] : 8'd0;
    pkt1.bytes  = wr_alpha_q ? tre_pkg::BytesRgba : tre_pkg::BytesRgb;
    pkt1.last   = 1'b1;
  end

  // transfer request towards the output queue
  always_comb begin
    push_o.count = take_i ? ({1'b0, close_run} + {1'b0, line_end}) : 2'd0;
    push_o.pkt_a = close_run ? pkt0 : pkt1;
    push_o.pkt_b = pkt1;
  end

  // next run state
  always_comb begin
    run_pix_d = new_pix;
    run_len_d = line_end ? 8'd0 : new_len;
    col_d     = line_end ? 16'd0 : col_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pix_q <= 32'd0;
      run_len_q <= 8'd0;
      col_q     <= 16'd0;
    end else if (take_i) begin
      run_pix_q <= run_pix_d;
      run_len_q <= run_len_d;
      col_q     <= col_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tre_out_queue.sv =====
// four-entry packet queue taking up to two packets and giving one per cycle unless out_stall_i holds it
`default_nettype none
module tre_out_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tre_pkg::push_t push_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tre_pkg::pkt_t      pkt_o
);

  tre_pkg::pkt_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] wr_ptr_nx;

  // room for two packets is needed before a pixel is taken
  assign full_o      = cnt_q > 3'd2;
  assign out_valid_o = cnt_q != 3'd0;
  assign pkt_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + 2'd1;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // packet storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.pkt_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.pkt_b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tga_rle_pixel_encoder.sv =====
// tga run-length pixel encoder top level
//
// Pixels enter on the input channel (in_valid_i / in_stall_o) in raster
// order, one per transfer, as four source bytes. Each transfer updates the
// open run at once and may produce zero, one or two run-length packets:
// the run it ends, then the run closed by the end of the line. Packets
// leave on the output channel (out_valid_o / out_stall_i), one per cycle
// while out_stall_i is low. Each packet is queued as its closing pixel is
// taken. A pixel is taken every cycle while the four-entry packet queue
// has room for two packets; with the receiver always ready the queue only
// backs up when line ends produce double packets, and it drains at one
// packet per cycle. If the receiver stalls, the queue fills and in_stall_o
// rises once fewer than two entries are free; a stalled packet holds
// steady. Configuration is a plain write port (index 0 source format, 1
// write alpha, 2 image width); the user must use it only while the block
// is idle, which the block does not enforce. Reset clears the run, the
// line column and the queue and sets the image width to one pixel.
`default_nettype none
module tga_rle_pixel_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  comp0_i,
  input  wire logic [7:0]  comp1_i,
  input  wire logic [7:0]  comp2_i,
  input  wire logic [7:0]  comp3_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       packet_header_o,
  output logic [7:0]       out_blue_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_alpha_o,
  output logic [2:0]       packet_bytes_o,
  output logic             last_of_item_o
);

  tre_pkg::push_t push;
  tre_pkg::pkt_t  pkt;
  logic           full;
  logic           take;

  // input transfer
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  tre_run_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .comp0_i     (comp0_i),
    .comp1_i     (comp1_i),
    .comp2_i     (comp2_i),
    .comp3_i     (comp3_i),
    .push_o      (push)
  );

  tre_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pkt_o       (pkt)
  );

  // output fields
  assign packet_header_o = pkt.header;
  assign out_blue_o      = pkt.blue;
  assign out_green_o     = pkt.green;
  assign out_red_o       = pkt.red;
  assign out_alpha_o     = pkt.alpha;
  assign packet_bytes_o  = pkt.bytes;
  assign last_of_item_o  = pkt.last;

endmodule
`default_nettype wire
